FILE: design/mpq_pkg.sv
// mpq_pkg: shared types and constants for the multilevel priority ready queue
// used by multilevel_priority_ready_queue; depends on nothing
`default_nettype none

package mpq_pkg;

  localparam int unsigned MaxProcsDef  = 16;
  localparam int unsigned NumLevelsDef = 8;
  localparam int unsigned PidW         = 4;
  localparam int unsigned PriW         = 3;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_REMOVE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_WR,
    ST_DEQ_CHK,
    ST_DEQ_WR,
    ST_HEAD_RD,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [PidW-1:0]  process_id;
    logic [PriW-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic [PidW-1:0]  running_process;
    logic [PriW-1:0]  running_level;
    logic             any_ready;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/mpq_ram.sv
// mpq_ram: generic single write port, single read port ram with registered read
// stand-alone; no package needed
`default_nettype none

module mpq_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/multilevel_priority_ready_queue.sv
// multilevel_priority_ready_queue: ready-queue scheduler, one linked fifo per level
// depends on mpq_pkg and mpq_ram (link, head and tail stores)
//
// usage: drive req_i and raise start while busy is low; the word is taken at
// that clock edge and busy stays high until the result has gone out. an
// enqueue appends process_id at the tail of its level (refused when the queue
// holds MAX_PROCS processes); a removal takes out the running process at the
// current level (refused when nothing is ready). every word gives exactly one
// result on rsp_o, shown for one cycle with done_o high; it cannot be held off.
// timing: the lists live in three small rams with registered read, stepped by
// one sequencer. a refused word goes straight to the head read and then the
// result state; an enqueue first writes its list, a removal first checks its
// level and, when a successor is fetched through the link store, then writes
// the new head; busy drops in the cycle after done_o, so no new word is taken
// before the last result has gone out.
// reset clears the level occupancy bits, current level and count; the rams
// hold no reset value and their contents are only used at entries already written.
`default_nettype none

module multilevel_priority_ready_queue #(
  parameter int unsigned MAX_PROCS  = mpq_pkg::MaxProcsDef,
  parameter int unsigned NUM_LEVELS = mpq_pkg::NumLevelsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire mpq_pkg::req_t req_i,
  output logic               busy,
  output logic               done_o,
  output mpq_pkg::rsp_t      rsp_o
);

  localparam int unsigned SlotW = $clog2(MAX_PROCS);
  localparam int unsigned LvlW  = $clog2(NUM_LEVELS);
  localparam int unsigned CntW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned PidW  = mpq_pkg::PidW;

  // link slot of a process id: id modulo MAX_PROCS by repeated subtraction
  function automatic logic [SlotW-1:0] slot_f(input logic [PidW-1:0] pid);
    logic [8:0] v;
    v = 9'(pid);
    for (int k = 0; k < 8; k++) begin
      if (v >= 9'(MAX_PROCS)) begin
        v = v - 9'(MAX_PROCS);
      end
    end
    return v[SlotW-1:0];
  endfunction

  function automatic logic [LvlW-1:0] top_f(input logic [NUM_LEVELS-1:0] ne);
    logic [LvlW-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ne[i]) begin
        lvl = LvlW'(i);
      end
    end
    return lvl;
  endfunction

  function automatic logic [LvlW-1:0] sat_f(input logic [mpq_pkg::PriW-1:0] pri);
    logic [LvlW-1:0] lvl;
    if (int'(pri) >= int'(NUM_LEVELS)) begin
      lvl = LvlW'(NUM_LEVELS - 1);
    end else begin
      lvl = LvlW'(pri);
    end
    return lvl;
  endfunction

  mpq_pkg::state_e state_q, state_d;

  logic [NUM_LEVELS-1:0] nonempty_q, nonempty_d;
  logic [LvlW-1:0]       current_q, current_d;
  logic [CntW-1:0]       total_q, total_d;
  logic                  ok_q, ok_d;
  logic [PidW-1:0]       pid_q;
  logic [LvlW-1:0]       pri_q;
  logic [LvlW-1:0]       lvl_q;

  logic [LvlW-1:0] lvl_idle;
  logic [LvlW-1:0] pri_in;
  logic            full;
  logic            accept;

  logic             head_we, tail_we, link_we;
  logic [LvlW-1:0]  head_waddr, head_raddr, tail_raddr;
  logic [PidW-1:0]  head_wdata;
  logic [SlotW-1:0] link_waddr, link_raddr;
  logic [PidW-1:0]  head_rd, tail_rd, link_rd;

  assign lvl_idle = nonempty_q[current_q] ? current_q : top_f(nonempty_q);
  assign pri_in   = sat_f(req_i.priority_req);
  assign full     = (total_q == CntW'(MAX_PROCS));
  assign accept   = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpq_pkg::ST_IDLE: begin
        if (start) begin
          if (req_i.op == mpq_pkg::OP_ENQUEUE) begin
            state_d = full ? mpq_pkg::ST_HEAD_RD : mpq_pkg::ST_ENQ_WR;
          end else begin
            state_d = (|nonempty_q) ? mpq_pkg::ST_DEQ_CHK : mpq_pkg::ST_HEAD_RD;
          end
        end
      end
      mpq_pkg::ST_ENQ_WR:  state_d = mpq_pkg::ST_HEAD_RD;
      mpq_pkg::ST_DEQ_CHK: begin
        state_d = (head_rd != tail_rd) ? mpq_pkg::ST_DEQ_WR : mpq_pkg::ST_HEAD_RD;
      end
      mpq_pkg::ST_DEQ_WR:  state_d = mpq_pkg::ST_HEAD_RD;
      mpq_pkg::ST_HEAD_RD: state_d = mpq_pkg::ST_RESULT;
      mpq_pkg::ST_RESULT:  state_d = mpq_pkg::ST_IDLE;
      default:             state_d = mpq_pkg::ST_IDLE;
    endcase
  end

  // ram control and queue bookkeeping
  always_comb begin
    head_we    = 1'b0;
    tail_we    = 1'b0;
    link_we    = 1'b0;
    head_waddr = pri_q;
    head_wdata = pid_q;
    head_raddr = current_q;
    tail_raddr = current_q;
    link_waddr = slot_f(tail_rd);
    link_raddr = slot_f(head_rd);
    nonempty_d = nonempty_q;
    current_d  = current_q;
    total_d    = total_q;
    ok_d       = ok_q;
    case (state_q)
      mpq_pkg::ST_IDLE: begin
        head_raddr = lvl_idle;
        tail_raddr = (req_i.op == mpq_pkg::OP_REMOVE) ? lvl_idle : pri_in;
        if (start) begin
          ok_d = (req_i.op == mpq_pkg::OP_ENQUEUE) ? !full : (|nonempty_q);
        end
      end
      mpq_pkg::ST_ENQ_WR: begin
        tail_we = 1'b1;
        if (nonempty_q[pri_q]) begin
          link_we = 1'b1;
        end else begin
          head_we = 1'b1;
        end
        nonempty_d[pri_q] = 1'b1;
        if (pri_q > current_q) begin
          current_d = pri_q;
        end
        total_d = total_q + CntW'(1);
      end
      mpq_pkg::ST_DEQ_CHK: begin
        if (head_rd != tail_rd) begin
          current_d = lvl_q;
        end else begin
          nonempty_d[lvl_q] = 1'b0;
          current_d         = top_f(nonempty_d);
        end
        if (total_q != '0) begin
          total_d = total_q - CntW'(1);
        end
      end
      mpq_pkg::ST_DEQ_WR: begin
        head_we    = 1'b1;
        head_waddr = lvl_q;
        head_wdata = link_rd;
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy                  = (state_q != mpq_pkg::ST_IDLE);
    done_o                = (state_q == mpq_pkg::ST_RESULT);
    rsp_o.accepted        = ok_q;
    rsp_o.any_ready       = |nonempty_q;
    rsp_o.running_process = (|nonempty_q) ? head_rd : '0;
    rsp_o.running_level   = (|nonempty_q) ? mpq_pkg::PriW'(current_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mpq_pkg::ST_IDLE;
      nonempty_q <= '0;
      current_q  <= '0;
      total_q    <= '0;
    end else begin
      state_q    <= state_d;
      nonempty_q <= nonempty_d;
      current_q  <= current_d;
      total_q    <= total_d;
    end
  end

  // word held for the length of the operation
  always_ff @(posedge clk_i) begin
    ok_q <= ok_d;
    if (accept) begin
      pid_q <= req_i.process_id;
      pri_q <= pri_in;
      lvl_q <= lvl_idle;
    end
  end

  mpq_ram #(
    .Width (PidW),
    .Depth (NUM_LEVELS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rd)
  );

  mpq_ram #(
    .Width (PidW),
    .Depth (NUM_LEVELS)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (pri_q),
    .wdata_i (pid_q),
    .raddr_i (tail_raddr),
    .rdata_o (tail_rd)
  );

  mpq_ram #(
    .Width (PidW),
    .Depth (MAX_PROCS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (pid_q),
    .raddr_i (link_raddr),
    .rdata_o (link_rd)
  );

endmodule

`default_nettype wire
